FILE: design/control_link_supervisor_core_defines.svh
// assertion macros shared by the link supervisor checker
`ifndef CONTROL_LINK_SUPERVISOR_CORE_DEFINES_SVH
`define CONTROL_LINK_SUPERVISOR_CORE_DEFINES_SVH

// implication checked in the same cycle
`define CLS_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// implication checked in the next cycle
`define CLS_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

FILE: design/cls_pkg.sv
// shared types, constants and helper functions for the link supervisor
package cls_pkg;

    localparam int DATA_BYTES  = 32;
    localparam int DATA_LANES  = DATA_BYTES / 8;
    localparam int DATA_WORDS  = DATA_BYTES / 2;
    localparam int SIG_W       = 2 * DATA_WORDS;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_CONTROL_TYPE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BREAK_TIME   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SILENCE_TIME = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERROR_LIMIT  = 2'd3;

    // configuration reset values
    localparam logic [7:0]  CONTROL_TYPE_RST = 8'd0;
    localparam logic [15:0] BREAK_TIME_RST   = 16'd500;
    localparam logic [15:0] SILENCE_TIME_RST = 16'd200;
    localparam logic [2:0]  ERROR_LIMIT_RST  = 3'd5;

    localparam logic [15:0] ELAPSED_MAX   = 16'hffff;
    localparam logic [2:0]  BAD_COUNT_MAX = 3'd7;

    // input kinds
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_PACKET = 1'b1;

    typedef logic [DATA_LANES-1:0][63:0] cls_data_t;

    typedef struct packed {
        logic             func;
        logic [7:0]       pkt_type;
        logic [31:0]      pkt_check;
        cls_data_t        data;
    } cls_item_t;

    typedef struct packed {
        logic             accepted;
        logic             link_break;
        logic             desynced;
        logic             receiver_reset;
        logic [SIG_W-1:0] computed_check;
    } cls_result_t;

    // divisibility by three: base-4 digit sum, then fold once more
    function automatic logic is_div3(input logic [15:0] w);
        logic [4:0] s;
        logic [2:0] t;
        s = 5'd0;
        for (int i = 0; i < 8; i++) begin
            s = s + 5'(w[2*i +: 2]);
        end
        t = 3'(s[4]) + 3'(s[3:2]) + 3'(s[1:0]);
        return (t == 3'd0) || (t == 3'd3) || (t == 3'd6);
    endfunction

endpackage

FILE: design/cls_signature.sv
// check signature over the 16 big-endian data words of a packet
module cls_signature (
    input  cls_pkg::cls_data_t               data,
    output logic [cls_pkg::SIG_W-1:0]        sig
);
    import cls_pkg::*;

    // one pair of signature bits per data word
    for (genvar k = 0; k < DATA_WORDS; k++) begin : g_word
        logic [15:0] word;
        assign word = data[k / 4][63 - 16 * (k % 4) -: 16];
        assign sig[2*k]     = is_div3(word);
        assign sig[2*k + 1] = ~word[0];
    end

endmodule

FILE: design/cls_supervisor.sv
// configuration registers, link state and per-request decision logic
module cls_supervisor (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [cls_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [cls_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  step,
    input  cls_pkg::cls_item_t                    item,
    input  logic [cls_pkg::SIG_W-1:0]             sig,
    output cls_pkg::cls_result_t                  result
);
    import cls_pkg::*;

    logic [7:0]  control_type_reg;
    logic [15:0] break_time_reg;
    logic [15:0] silence_time_reg;
    logic [2:0]  error_limit_reg;

    logic [15:0] elapsed_reg, elapsed_next;
    logic [2:0]  bad_count_reg, bad_count_next;
    logic        break_reg, break_next;
    logic        desync_reg, desync_next;

    logic [15:0] elapsed_inc;
    logic [2:0]  bad_inc;
    logic        valid_pkt;
    logic        accepted;
    logic        rx_reset;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_type_reg <= CONTROL_TYPE_RST;
            break_time_reg   <= BREAK_TIME_RST;
            silence_time_reg <= SILENCE_TIME_RST;
            error_limit_reg  <= ERROR_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CONTROL_TYPE: control_type_reg <= cfg_data[7:0];
                CFG_BREAK_TIME:   break_time_reg   <= cfg_data;
                CFG_SILENCE_TIME: silence_time_reg <= cfg_data;
                CFG_ERROR_LIMIT:  error_limit_reg  <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // saturating counters
    assign elapsed_inc = (elapsed_reg != ELAPSED_MAX) ? elapsed_reg + 16'd1 : elapsed_reg;
    assign bad_inc     = (bad_count_reg != BAD_COUNT_MAX) ? bad_count_reg + 3'd1 : bad_count_reg;
    assign valid_pkt   = (item.pkt_type == control_type_reg) && (item.pkt_check == sig);

    // next link state for the request in the input register
    always_comb
    begin
        elapsed_next   = elapsed_reg;
        bad_count_next = bad_count_reg;
        break_next     = break_reg;
        desync_next    = desync_reg;
        accepted       = 1'b0;
        rx_reset       = 1'b0;
        if (item.func == FUNC_PACKET)
        begin
            elapsed_next = 16'd0;
            if (!desync_reg)
            begin
                if (valid_pkt)
                begin
                    accepted       = 1'b1;
                    bad_count_next = 3'd0;
                    break_next     = 1'b0;
                end
                else
                begin
                    bad_count_next = bad_inc;
                    if (bad_inc >= error_limit_reg)
                    begin
                        desync_next = 1'b1;
                    end
                end
            end
        end
        else
        begin
            elapsed_next = elapsed_inc;
            if (desync_reg && (elapsed_inc > silence_time_reg))
            begin
                rx_reset    = 1'b1;
                desync_next = 1'b0;
            end
            if (elapsed_inc > break_time_reg)
            begin
                break_next = 1'b1;
            end
        end
    end

    // state advances once per processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg   <= 16'd0;
            bad_count_reg <= 3'd0;
            break_reg     <= 1'b0;
            desync_reg    <= 1'b0;
        end
        else if (step)
        begin
            elapsed_reg   <= elapsed_next;
            bad_count_reg <= bad_count_next;
            break_reg     <= break_next;
            desync_reg    <= desync_next;
        end
    end

    // result fields for this request
    always_comb
    begin
        result.accepted       = accepted;
        result.link_break     = break_next;
        result.desynced       = desync_next;
        result.receiver_reset = rx_reset;
        result.computed_check = (item.func == FUNC_PACKET) ? sig : '0;
    end

endmodule

FILE: design/control_link_supervisor_core.sv
// top level of the control link supervisor
// Takes one request per cycle while results are drained, either a millisecond tick or a
// whole received packet, and returns one result per request in order. A request is held
// in an input register, then the packet signature, the type and check compare and the
// link state update run combinationally into the result register; sustained throughput is
// one request per clock while res_ready stays high. The link state (elapsed time, error
// count, break and desync flags) updates in the same cycle the result is registered, so
// back-to-back requests see each other's effect. Configuration registers are written
// through cfg_we/cfg_index/cfg_data while idle by the user; the core does not enforce it.
module control_link_supervisor_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cls_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [cls_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  logic                             func,
    input  logic [7:0]                       pkt_type,
    input  logic [31:0]                      pkt_check,
    input  logic [63:0]                      data_bytes_0_7,
    input  logic [63:0]                      data_bytes_8_15,
    input  logic [63:0]                      data_bytes_16_23,
    input  logic [63:0]                      data_bytes_24_31,
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic                             accepted,
    output logic                             link_break,
    output logic                             desynced,
    output logic                             receiver_reset,
    output logic [31:0]                      computed_check
);
    import cls_pkg::*;

    logic        item_valid_reg;
    cls_item_t   item_reg;
    logic        res_valid_reg;
    cls_result_t result_reg;
    cls_result_t result_next;
    logic [SIG_W-1:0] sig;
    logic        res_free;
    logic        step;

    // pipeline advance
    assign res_free  = !res_valid_reg || res_ready;
    assign step      = item_valid_reg && res_free;
    assign req_ready = !item_valid_reg || res_free;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            item_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg.func      <= func;
            item_reg.pkt_type  <= pkt_type;
            item_reg.pkt_check <= pkt_check;
            item_reg.data[0]   <= data_bytes_0_7;
            item_reg.data[1]   <= data_bytes_8_15;
            item_reg.data[2]   <= data_bytes_16_23;
            item_reg.data[3]   <= data_bytes_24_31;
        end
    end

    cls_signature u_sig (
        .data (item_reg.data),
        .sig  (sig)
    );

    cls_supervisor u_sup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (step),
        .item      (item_reg),
        .sig       (sig),
        .result    (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            result_reg <= result_next;
        end
    end

    assign res_valid      = res_valid_reg;
    assign accepted       = result_reg.accepted;
    assign link_break     = result_reg.link_break;
    assign desynced       = result_reg.desynced;
    assign receiver_reset = result_reg.receiver_reset;
    assign computed_check = result_reg.computed_check;

endmodule

FILE: design/cls_checker.sv
// port-level checks on the link supervisor results, bound to the top level
`include "control_link_supervisor_core_defines.svh"

module cls_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        res_valid,
    input logic        res_ready,
    input logic        accepted,
    input logic        link_break,
    input logic        desynced,
    input logic        receiver_reset,
    input logic [31:0] computed_check
);

    // a stalled result holds
    `CLS_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable({accepted, link_break, desynced, receiver_reset, computed_check}), "stalled result changed")

    // an accepted packet leaves the link in sync and unbroken
    `CLS_ASSERT_NOW(a_accept_flags, res_valid && accepted, !desynced && !link_break, "accepted packet with bad status")

    // a receiver reset comes from a tick and resyncs the link
    `CLS_ASSERT_NOW(a_rx_reset_tick, res_valid && receiver_reset, !accepted && (computed_check == 32'd0) && !desynced, "receiver reset on a non-tick result")

endmodule

bind control_link_supervisor_core cls_checker u_cls_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .accepted       (accepted),
    .link_break     (link_break),
    .desynced       (desynced),
    .receiver_reset (receiver_reset),
    .computed_check (computed_check)
);
